FILE: hw/rtl/sda_pkg.sv
`default_nettype none

package sda_pkg;

  // Image store geometry and subsample grid
  localparam int MaxWidth  = 256;
  localparam int MaxHeight = 256;
  localparam int Sub       = 16;

  localparam int ColW  = $clog2(MaxWidth);
  localparam int RowW  = $clog2(MaxHeight);
  localparam int AddrW = ColW + RowW;
  localparam int Depth = MaxWidth * MaxHeight;
  localparam int SubW  = $clog2(Sub);

  // Field widths
  localparam int CoordW = 18;
  localparam int RadW   = 14;
  localparam int DimW   = 9;
  localparam int PixW   = 24;
  localparam int BoundW = CoordW + 2;

  // Squarer: offsets scaled by the subsample step fit 16 bits signed
  localparam int SqInW = 16;
  localparam int SqW   = 30;
  localparam int R2W   = 2 * RadW;

  localparam int CntW  = $clog2(Sub * Sub + 1);
  localparam int LaneW = $clog2(Sub + 1);
  localparam int StepW = $clog2(2 * Sub + 2);

  localparam logic [StepW-1:0] StepLane  = StepW'(Sub);
  localparam logic [StepW-1:0] StepWrite = StepW'(2 * Sub + 1);

  localparam logic [CntW-1:0] Threshold = CntW'(Sub * Sub / 2 - 1);
  localparam logic [CntW-1:0] FullValue = CntW'(255);
  localparam logic [PixW-1:0] SumMax    = {PixW{1'b1}};

  typedef enum logic [1:0] {
    CMD_DRAW  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_SMOOTH = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_BOX,
    ST_PIX,
    ST_RDATA,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [PixW-1:0]  wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } store_req_t;

  // Truncate a 1/256-unit value toward zero and clamp into [0, lim]
  function automatic logic [DimW-1:0] box_bound(input logic signed [BoundW-1:0] v,
                                                input logic [DimW-1:0] lim);
    logic [BoundW-9:0] p;
    p = v[BoundW-1:8];
    if (v[BoundW-1]) begin
      box_bound = '0;
    end else if (p > (BoundW-8)'(lim)) begin
      box_bound = lim;
    end else begin
      box_bound = p[DimW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sda_squarer.sv
`default_nettype none

module sda_squarer (
  input  logic                             clk_i,
  input  logic signed [sda_pkg::SqInW-1:0] op_i,
  output logic        [sda_pkg::SqW-1:0]   sq_o
);
  import sda_pkg::*;

  logic signed [2*SqInW-1:0] prod;
  logic        [SqW-1:0]     sq_q;

  assign prod = op_i * op_i;

  always_ff @(posedge clk_i) begin
    sq_q <= prod[SqW-1:0];
  end

  assign sq_o = sq_q;

endmodule

`default_nettype wire

FILE: hw/rtl/sda_store.sv
`default_nettype none

module sda_store (
  input  logic                       clk_i,
  input  sda_pkg::store_req_t        req_i,
  output logic [sda_pkg::PixW-1:0]   rdata_o
);
  import sda_pkg::*;

  logic [PixW-1:0] mem_q [Depth];
  logic [PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/supersampled_disk_accumulator_unit.sv
`default_nettype none

// Channel   Dir  Handshake                        Payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  cmd (tuser); center_x, center_y, radius, col, row
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  pixel_value, saturated
// apb       in   psel & penable & pwrite          smooth_edges, image_width, image_height
//
// One command at a time. A draw passes through ST_SETUP and ST_BOX, then steps through each pixel of
// the clipped box (16 squarings of row offsets, 16 of column offsets through the one
// shared squarer, each column step tested against 16 lanes), then reports from ST_FINISH.
// A read passes through ST_RDATA; a clear writes all 65536 store words (one store word per cycle).
// After reset the store is swept to zero with s_axis_tready_o low.
// A result waits in the output register while the next command is taken.

module supersampled_disk_accumulator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // s_axis_tuser_i: cmd[1:0]
  // s_axis_tdata_i: center_x[17:0], center_y[35:18], radius[49:36],
  //                 read_col[57:50], read_row[65:58], zero[71:66]
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [1:0]  s_axis_tuser_i,
  input  logic [71:0] s_axis_tdata_i,
  // m_axis_tdata_o: pixel_value[23:0], saturated[24], zero[31:25]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sda_pkg::*;

  // ---------------- configuration ----------------
  logic            smooth_q;
  logic [DimW-1:0] width_q;
  logic [DimW-1:0] height_q;
  logic            cfg_wr;
  reg_e            cfg_reg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_reg = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= 1'b1;
      width_q  <= DimW'(MaxWidth);
      height_q <= DimW'(MaxHeight);
    end else if (cfg_wr) begin
      case (cfg_reg)
        REG_SMOOTH: smooth_q <= pwdata[0];
        REG_WIDTH:  width_q  <= pwdata[DimW-1:0];
        REG_HEIGHT: height_q <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      REG_SMOOTH: prdata = {31'd0, smooth_q};
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------- input fields ----------------
  logic [1:0]        in_cmd;
  logic [CoordW-1:0] in_cx;
  logic [CoordW-1:0] in_cy;
  logic [RadW-1:0]   in_r;
  logic [ColW-1:0]   in_col;
  logic [RowW-1:0]   in_row;
  logic              in_xfer;

  assign in_cmd  = s_axis_tuser_i;
  assign in_cx   = s_axis_tdata_i[17:0];
  assign in_cy   = s_axis_tdata_i[35:18];
  assign in_r    = s_axis_tdata_i[49:36];
  assign in_col  = s_axis_tdata_i[57:50];
  assign in_row  = s_axis_tdata_i[65:58];
  assign in_xfer = s_axis_tvalid_i & s_axis_tready_o;

  // ---------------- state ----------------
  state_e           state_q, state_d;
  logic             clr_report_q;
  logic [AddrW-1:0] clr_addr_q;
  logic [CoordW-1:0] cx_q, cy_q;
  logic [RadW-1:0]  r_q;
  logic [R2W-1:0]   r2_q;
  logic [DimW-1:0]  i1_q, i2_q, j1_q, j2_q;
  logic [ColW-1:0]  i_q;
  logic [RowW-1:0]  j_q;
  logic [StepW-1:0] step_q;
  logic [CntW-1:0]  count_q;
  logic [SqW-1:0]   dy2_q [Sub];
  logic             sat_q;
  logic [PixW-1:0]  res_pix_q;
  logic             out_valid_q;
  logic [PixW-1:0]  out_pix_q;
  logic             out_sat_q;

  store_req_t       store_req;
  logic [PixW-1:0]  store_rdata;
  logic signed [SqInW-1:0] sq_op;
  logic [SqW-1:0]   sq;

  sda_squarer u_squarer (
    .clk_i (clk_i),
    .op_i  (sq_op),
    .sq_o  (sq)
  );

  sda_store u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .rdata_o (store_rdata)
  );

  // ---------------- box and offset arithmetic ----------------
  logic [DimW-1:0]          w_clip, h_clip;
  logic signed [BoundW-1:0] cx_s, cy_s, r_s;
  logic [DimW-1:0]          i1_c, i2_c, j1_c, j2_c;
  logic                     box_empty;

  assign w_clip = (width_q > DimW'(MaxWidth)) ? DimW'(MaxWidth) : width_q;
  assign h_clip = (height_q > DimW'(MaxHeight)) ? DimW'(MaxHeight) : height_q;
  assign cx_s   = BoundW'(signed'(cx_q));
  assign cy_s   = BoundW'(signed'(cy_q));
  assign r_s    = signed'(BoundW'(r_q));
  assign i1_c   = box_bound(cx_s - r_s - BoundW'(256), w_clip);
  assign i2_c   = box_bound(cx_s + r_s + BoundW'(512), w_clip);
  assign j1_c   = box_bound(cy_s - r_s - BoundW'(256), h_clip);
  assign j2_c   = box_bound(cy_s + r_s + BoundW'(512), h_clip);
  assign box_empty = (i1_q >= i2_q) || (j1_q >= j2_q);

  // Offsets from the centre in 1/(256*Sub) pixel units divided by Sub
  logic [BoundW-1:0]        dy_base, dx_base;
  logic signed [BoundW-1:0] dy_off, dx_off;

  assign dy_base = BoundW'({j_q, 8'd0}) + BoundW'({step_q[SubW-1:0], 4'd0});
  assign dx_base = BoundW'({i_q, 8'd0}) + BoundW'({step_q[SubW-1:0], 4'd0});
  assign dy_off  = signed'(dy_base) - cy_s;
  assign dx_off  = signed'(dx_base) - cx_s;

  // ---------------- lane compare ----------------
  logic [LaneW-1:0] lane_hits;
  logic [SubW-1:0]  lane_idx;

  assign lane_idx = SubW'(step_q - StepW'(1));

  always_comb begin
    lane_hits = '0;
    for (int l = 0; l < Sub; l++) begin
      if (({1'b0, sq} + {1'b0, dy2_q[l]}) <= (SqW+1)'(r2_q)) begin
        lane_hits = lane_hits + LaneW'(1);
      end
    end
  end

  // ---------------- pixel update ----------------
  logic [CntW-1:0]   add_val;
  logic [PixW:0]     sum_raw;
  logic              sum_ovf;
  logic [PixW-1:0]   sum_new;
  logic [DimW-1:0]   j_inc, i_inc;
  logic              row_wrap, last_pix, pix_write;

  assign add_val = smooth_q ? count_q : ((count_q > Threshold) ? FullValue : '0);
  assign sum_raw = {1'b0, store_rdata} + (PixW+1)'(add_val);
  assign sum_ovf = sum_raw[PixW];
  assign sum_new = sum_ovf ? SumMax : sum_raw[PixW-1:0];
  assign j_inc   = DimW'(j_q) + DimW'(1);
  assign i_inc   = DimW'(i_q) + DimW'(1);
  assign row_wrap  = (j_inc == j2_q);
  assign pix_write = (state_q == ST_PIX) && (step_q == StepWrite);
  assign last_pix  = pix_write && row_wrap && (i_inc == i2_q);

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == {AddrW{1'b1}}) begin
          state_d = clr_report_q ? ST_FINISH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          case (cmd_e'(in_cmd))
            CMD_DRAW:  state_d = ST_SETUP;
            CMD_READ:  state_d = ST_RDATA;
            CMD_CLEAR: state_d = ST_CLEAR;
            default:   state_d = ST_FINISH;
          endcase
        end
      end
      ST_SETUP:  state_d = ST_BOX;
      ST_BOX:    state_d = box_empty ? ST_FINISH : ST_PIX;
      ST_PIX:    state_d = last_pix ? ST_FINISH : ST_PIX;
      ST_RDATA:  state_d = ST_FINISH;
      ST_FINISH: state_d = out_free ? ST_IDLE : ST_FINISH;
      default:   state_d = ST_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    store_req       = '0;
    sq_op           = '0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        store_req.we    = 1'b1;
        store_req.waddr = clr_addr_q;
      end
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        store_req.re    = in_xfer && (cmd_e'(in_cmd) == CMD_READ);
        store_req.raddr = {in_col, in_row};
      end
      ST_SETUP: begin
        sq_op = signed'(SqInW'(r_q));
      end
      ST_PIX: begin
        // square row offsets first, then column offsets
        sq_op = (step_q < StepLane) ? dy_off[SqInW-1:0] : dx_off[SqInW-1:0];
        store_req.re    = (step_q == '0);
        store_req.raddr = {i_q, j_q};
        store_req.we    = pix_write;
        store_req.waddr = {i_q, j_q};
        store_req.wdata = sum_new;
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_report_q <= 1'b0;
      clr_addr_q   <= '0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
      end
      if (in_xfer && (cmd_e'(in_cmd) == CMD_CLEAR)) begin
        clr_report_q <= 1'b1;
      end
      if (state_q == ST_PIX) begin
        step_q <= (step_q == StepWrite) ? '0 : step_q + StepW'(1);
      end else begin
        step_q <= '0;
      end
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cx_q      <= in_cx;
      cy_q      <= in_cy;
      r_q       <= in_r;
      sat_q     <= 1'b0;
      res_pix_q <= '0;
    end
    if (state_q == ST_SETUP) begin
      i1_q <= i1_c;
      i2_q <= i2_c;
      j1_q <= j1_c;
      j2_q <= j2_c;
    end
    if (state_q == ST_BOX) begin
      r2_q <= sq[R2W-1:0];
      i_q  <= i1_q[ColW-1:0];
      j_q  <= j1_q[RowW-1:0];
    end
    if (state_q == ST_RDATA) begin
      res_pix_q <= store_rdata;
    end
    if (state_q == ST_PIX) begin
      if (step_q == '0) begin
        count_q <= '0;
      end
      if (step_q != '0 && step_q <= StepLane) begin
        dy2_q[lane_idx] <= sq;
      end
      if (step_q > StepLane && step_q < StepWrite) begin
        count_q <= count_q + CntW'(lane_hits);
      end
      if (pix_write) begin
        if (sum_ovf) begin
          sat_q <= 1'b1;
        end
        // advance down the column, wrap to the next one
        if (row_wrap) begin
          j_q <= j1_q[RowW-1:0];
          i_q <= i_inc[ColW-1:0];
        end else begin
          j_q <= j_inc[RowW-1:0];
        end
      end
    end
    if (state_q == ST_FINISH && out_free) begin
      out_pix_q <= res_pix_q;
      out_sat_q <= sat_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_sat_q, out_pix_q};

  // ---------------- assertions ----------------
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready_o)
    else $error("input taken while a command is in progress");

  a_store_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(store_req.we && store_req.re))
    else $error("store read and write in the same cycle");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PIX) |-> (step_q <= StepWrite))
    else $error("pixel step counter out of range");

  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_free) |=> (state_q == ST_IDLE && out_valid_q))
    else $error("finished command did not post its result");

endmodule

`default_nettype wire
